### hdl/mefb_pkg.sv
// Shared types, field layout and constants for the mono expansion framebuffer blitter.
package mefb_pkg;

    localparam int CMD_W      = 2;
    localparam int POS_W      = 10;
    localparam int GW_W       = 7;
    localparam int GH_W       = 10;
    localparam int ROW_W      = 10;
    localparam int BITS_W     = 64;
    localparam int SHIFT_W    = 10;
    localparam int SIZE_W     = 11;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int X_LSB     = 0;
    localparam int Y_LSB     = X_LSB + POS_W;
    localparam int GW_LSB    = Y_LSB + POS_W;
    localparam int GH_LSB    = GW_LSB + GW_W;
    localparam int ROW_LSB   = GH_LSB + GH_W;
    localparam int BITS_LSB  = ROW_LSB + ROW_W;
    localparam int SH_LSB    = BITS_LSB + BITS_W;
    localparam int S_FIELD_W = SH_LSB + SHIFT_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = COLOR_W;

    localparam int DEF_MAX_WIDTH       = 1024;
    localparam int DEF_MAX_HEIGHT      = 1024;
    localparam int DEF_MAX_GLYPH_WIDTH = 64;

    localparam logic [SIZE_W-1:0]  RST_OSD_WIDTH  = SIZE_W'(720);
    localparam logic [SIZE_W-1:0]  RST_OSD_HEIGHT = SIZE_W'(576);
    localparam logic [COLOR_W-1:0] RST_FG_COLOR   = 32'h00ff_ffff;
    localparam logic [COLOR_W-1:0] RST_BG_COLOR   = 32'hff00_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_DRAW   = 2'd1,
        CMD_SCROLL = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OSD_WIDTH  = 2'd0,
        REG_OSD_HEIGHT = 2'd1,
        REG_FG_COLOR   = 2'd2,
        REG_BG_COLOR   = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_LINE,
        OP_MUL_SHIFT,
        OP_SETUP,
        OP_FILL,
        OP_COPY,
        OP_FILL_START,
        OP_LOAD_OUT
    } t_dp_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_MUL_SHIFT,
        S_SETUP,
        S_FILL,
        S_COPY,
        S_RWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic cnt_zero;
        logic no_work;
        logic out_free;
    } t_dp_sts;

endpackage

### hdl/mono_expand_framebuffer_blitter.sv
// Top level of the monochrome color-expansion blitter over a 32-bit frame store.
// One command is taken at a time and gives one result transaction. The frame store is a
// single-port-write, single-port-read memory, so the cost is set by one pixel per cycle:
// clear writes width*height words, scroll as many (copy then fill, one word each cycle),
// a glyph row glyph_width words (up to 64), a read nothing (it reads one word),
// and a skipped or empty command none. A new command is taken while the previous result
// still waits on the output register. The store is not cleared after reset; issue a clear
// before reading pixels.
module mono_expand_framebuffer_blitter import mefb_pkg::*; #(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // pos_x[9:0], pos_y[19:10], glyph_width[26:20], glyph_height[36:27],
    // row_index[46:37], row_bits[110:47], shift_lines[120:111], zero[127:121]
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]      i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // pixel_value[31:0]
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // skipped[0]
    output logic                  o_m_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    mefb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mefb_dp #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_one_cmd_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken again right after a transaction");

    a_skip_has_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("skipped draw carries a pixel value");

    a_result_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.op == OP_LOAD_OUT |-> (!o_m_tvalid || i_m_tready))
        else $error("result loaded over a pending transaction");
`endif

endmodule

### hdl/mefb_dp.sv
// Datapath: configuration registers, command fields, address counters, frame store, result register.
module mefb_dp import mefb_pkg::*; #(
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = DEF_MAX_HEIGHT,
    parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,
    input  logic [CMD_W-1:0]      i_s_tuser,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic                  o_m_tuser
);

    localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int CW          = $clog2(STORE_WORDS + 1);
    localparam int PW          = 2 * SIZE_W;

    logic [SIZE_W-1:0]  r_osd_width;
    logic [SIZE_W-1:0]  r_osd_height;
    logic [COLOR_W-1:0] r_fg_color;
    logic [COLOR_W-1:0] r_bg_color;

    t_cmd               r_cmd;
    logic [POS_W-1:0]   r_x;
    logic [POS_W-1:0]   r_y;
    logic [GW_W-1:0]    r_w;
    logic [GH_W-1:0]    r_h;
    logic [ROW_W-1:0]   r_row;
    logic [BITS_W-1:0]  r_bits;
    logic [SHIFT_W-1:0] r_shift;

    logic [CW-1:0]      r_prod;
    logic [CW-1:0]      r_off;
    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_waddr;
    logic [AW-1:0]      r_raddr;
    logic               r_cp_vld;
    logic [COLOR_W-1:0] r_rdata;
    logic [COLOR_W-1:0] r_mem [STORE_WORDS];

    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_pixel;
    logic               r_out_skip;

    logic [GW_W-1:0]    in_w;
    logic [SIZE_W-1:0]  ow;
    logic [SIZE_W-1:0]  oh;
    logic [SIZE_W:0]    x_end;
    logic [SIZE_W:0]    y_end;
    logic               edge_hit;
    logic               row_out;
    logic               read_out;
    logic [SIZE_W-1:0]  sat_shift;
    logic [SIZE_W-1:0]  line_opnd;
    logic [SIZE_W-1:0]  mul_a;
    logic [PW-1:0]      mul_full;
    logic               mem_we;
    logic [COLOR_W-1:0] mem_wdata;
    logic               out_free;

    assign in_w = (i_s_tdata[GW_LSB +: GW_W] > GW_W'(MAX_GLYPH_WIDTH)) ?
                  GW_W'(MAX_GLYPH_WIDTH) : i_s_tdata[GW_LSB +: GW_W];

    assign ow = (32'(r_osd_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : r_osd_width;
    assign oh = (32'(r_osd_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_osd_height;

    assign x_end    = (SIZE_W+1)'(r_x) + (SIZE_W+1)'(r_w);
    assign y_end    = (SIZE_W+1)'(r_y) + (SIZE_W+1)'(r_h);
    assign edge_hit = (x_end > (SIZE_W+1)'(ow)) || (y_end > (SIZE_W+1)'(oh));
    assign row_out  = r_row >= r_h;
    assign read_out = (SIZE_W'(r_x) >= ow) || (SIZE_W'(r_y) >= oh);

    assign sat_shift = (SIZE_W'(r_shift) > oh) ? oh : SIZE_W'(r_shift);

    always_comb begin
        case (r_cmd)
            CMD_DRAW: line_opnd = SIZE_W'(r_y) + SIZE_W'(r_row);
            CMD_READ: line_opnd = SIZE_W'(r_y);
            default:  line_opnd = oh;
        endcase
    end

    assign mul_a    = (i_cmd.op == OP_MUL_SHIFT) ? sat_shift : line_opnd;
    assign mul_full = PW'(mul_a) * PW'(ow);

    assign mem_we    = (i_cmd.op == OP_FILL) || r_cp_vld;
    assign mem_wdata = r_cp_vld ? r_rdata :
                       ((r_cmd == CMD_DRAW) && r_bits[BITS_W-1]) ? r_fg_color : r_bg_color;

    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_sts.cmd      = r_cmd;
        o_sts.cnt_zero = (r_count == '0);
        o_sts.out_free = out_free;
        case (r_cmd)
            CMD_DRAW: o_sts.no_work = edge_hit || row_out;
            CMD_READ: o_sts.no_work = read_out;
            default:  o_sts.no_work = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osd_width  <= RST_OSD_WIDTH;
            r_osd_height <= RST_OSD_HEIGHT;
            r_fg_color   <= RST_FG_COLOR;
            r_bg_color   <= RST_BG_COLOR;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_OSD_WIDTH:  r_osd_width  <= i_cfg_data[SIZE_W-1:0];
                REG_OSD_HEIGHT: r_osd_height <= i_cfg_data[SIZE_W-1:0];
                REG_FG_COLOR:   r_fg_color   <= i_cfg_data[COLOR_W-1:0];
                REG_BG_COLOR:   r_bg_color   <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_cmd   <= t_cmd'(i_s_tuser);
            r_x     <= i_s_tdata[X_LSB +: POS_W];
            r_y     <= i_s_tdata[Y_LSB +: POS_W];
            r_w     <= in_w;
            r_h     <= i_s_tdata[GH_LSB +: GH_W];
            r_row   <= i_s_tdata[ROW_LSB +: ROW_W];
            r_bits  <= i_s_tdata[BITS_LSB +: BITS_W];
            r_shift <= i_s_tdata[SH_LSB +: SHIFT_W];
        end else if (i_cmd.op == OP_FILL) begin
            r_bits <= {r_bits[BITS_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_vld <= 1'b0;
            r_count  <= '0;
        end else begin
            r_cp_vld <= (i_cmd.op == OP_COPY);
            case (i_cmd.op)
                OP_MUL_LINE:  r_prod <= CW'(mul_full);
                OP_MUL_SHIFT: r_off  <= CW'(mul_full);
                OP_SETUP: begin
                    case (r_cmd)
                        CMD_CLEAR: begin
                            r_waddr <= '0;
                            r_count <= r_prod;
                        end
                        CMD_DRAW: begin
                            r_waddr <= AW'(r_prod) + AW'(r_x);
                            r_count <= CW'(r_w);
                        end
                        CMD_SCROLL: begin
                            r_waddr <= '0;
                            r_raddr <= AW'(r_off);
                            r_count <= r_prod - r_off;
                            r_fill  <= r_off;
                        end
                        default: begin
                            r_raddr <= AW'(r_prod) + AW'(r_x);
                        end
                    endcase
                end
                OP_FILL: begin
                    r_waddr <= r_waddr + AW'(1);
                    r_count <= r_count - CW'(1);
                end
                OP_COPY: begin
                    r_raddr <= r_raddr + AW'(1);
                    r_count <= r_count - CW'(1);
                    if (r_cp_vld) begin
                        r_waddr <= r_waddr + AW'(1);
                    end
                end
                OP_FILL_START: begin
                    r_count <= r_fill;
                    if (r_cp_vld) begin
                        r_waddr <= r_waddr + AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_LOAD_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD_OUT) begin
            r_out_pixel <= ((r_cmd == CMD_READ) && !read_out) ? r_rdata : '0;
            r_out_skip  <= (r_cmd == CMD_DRAW) && edge_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;
    assign o_m_tuser  = r_out_skip;

endmodule

### hdl/mefb_ctrl.sv
// Controller state machine that sequences the datapath for each command.
module mefb_ctrl import mefb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.op = OP_MUL_LINE;
                if (i_sts.no_work) begin
                    n_state = S_DONE;
                end else if (i_sts.cmd == CMD_SCROLL) begin
                    n_state = S_MUL_SHIFT;
                end else begin
                    n_state = S_SETUP;
                end
            end
            S_MUL_SHIFT: begin
                o_cmd.op = OP_MUL_SHIFT;
                n_state  = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.op = OP_SETUP;
                case (i_sts.cmd)
                    CMD_SCROLL: n_state = S_COPY;
                    CMD_READ:   n_state = S_RWAIT;
                    default:    n_state = S_FILL;
                endcase
            end
            S_COPY: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.op = OP_FILL_START;
                    n_state  = S_FILL;
                end else begin
                    o_cmd.op = OP_COPY;
                end
            end
            S_FILL: begin
                if (i_sts.cnt_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_FILL;
                end
            end
            S_RWAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_LOAD_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
